@@ rtl/blq_pkg.sv @@
package blq_pkg;

  localparam int BLQ_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 5;

  // command kinds as seen on the input channel
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_AFTER   = 2'd2;
  localparam logic [1:0] KIND_BEFORE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // operation broadcast to every cell, already gated by success
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_POP,
    OP_AFTER,
    OP_BEFORE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  new_value;
    logic signed [DATA_W-1:0]  target_value;
  } cell_ctrl_t;

  // handed from a cell to its rear neighbor
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     occ;
    logic                     hit;
    logic                     first;
  } fwd_link_t;

  // handed from a cell to its front neighbor
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     occ;
  } bwd_link_t;

endpackage

@@ rtl/blq_cmd_if.sv @@
interface blq_cmd_if
  import blq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] target_value;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, kind, target_value, new_value, input ready);
  modport sink   (input valid, kind, target_value, new_value, output ready);
endinterface

@@ rtl/blq_res_if.sv @@
interface blq_res_if
  import blq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] removed_value;
  logic [COUNT_OUT_W-1:0]   entry_count;

  modport source (output valid, status, removed_value, entry_count, input ready);
  modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

@@ rtl/bounded_list_queue.sv @@
// result: an accepted command's status, removed value and count are registered
// throughput: one command per cycle while results are taken; the search ripples
//   hit flags through the row of cells, so its length grows with CAPACITY
// reset: synchronous active-low rst_n clears the count, the cell occupied flags
//   and the output valid; entry values are not reset
module bounded_list_queue
  import blq_pkg::*;
#(
  parameter int CAPACITY = BLQ_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  blq_cmd_if.sink    in_cmd,
  blq_res_if.source  out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // front-to-rear and rear-to-front links between neighboring cells
  fwd_link_t  fwd [CAPACITY+1];
  bwd_link_t  bwd [CAPACITY+1];
  cell_ctrl_t ctrl;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic [1:0]               status_r, status_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  logic accept;
  logic full, empty, found;

  // chain ends: front of the row counts as occupied, rear as empty
  assign fwd[0]        = '{value: '0, occ: 1'b1, hit: 1'b0, first: 1'b0};
  assign bwd[CAPACITY] = '{value: '0, occ: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    blq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .from_front (fwd[i]),
      .from_rear  (bwd[i+1]),
      .to_rear    (fwd[i+1]),
      .to_front   (bwd[i])
    );
  end

  // occupancy comes straight from the end cells' flags
  assign full  = fwd[CAPACITY].occ;
  assign empty = !bwd[0].occ;
  assign found = fwd[CAPACITY].hit;

  // output register frees the input side as soon as the result is taken
  assign in_cmd.ready = !out_valid_r || out_res.ready;
  assign accept       = in_cmd.valid && in_cmd.ready;

  always_comb begin
    ctrl.new_value    = in_cmd.new_value;
    ctrl.target_value = in_cmd.target_value;
    ctrl.op           = OP_NONE;
    status_nxt        = ST_OK;
    removed_nxt       = '0;
    count_nxt         = count_r;
    case (in_cmd.kind)
      KIND_ENQUEUE: begin
        if (full) status_nxt = ST_FULL;
        else      ctrl.op    = OP_APPEND;
      end
      KIND_DEQUEUE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.op     = OP_POP;
          removed_nxt = bwd[0].value;
        end
      end
      KIND_AFTER, KIND_BEFORE: begin
        // empty is reported ahead of full, then a missing target
        if (empty)       status_nxt = ST_EMPTY;
        else if (full)   status_nxt = ST_FULL;
        else if (!found) status_nxt = ST_NOTFOUND;
        else ctrl.op = (in_cmd.kind == KIND_AFTER) ? OP_AFTER : OP_BEFORE;
      end
      default: ;
    endcase
    if (!accept) ctrl.op = OP_NONE;
    case (ctrl.op)
      OP_POP:                         count_nxt = count_r - CNT_W'(1);
      OP_APPEND, OP_AFTER, OP_BEFORE: count_nxt = count_r + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept)             out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  // entry count carries the low bits of the held count after the command
  logic [CNT_W-1:0] count_out_r;
  always_ff @(posedge clk) begin
    if (accept) count_out_r <= count_nxt;
  end
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_out_r};

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = status_r;
  assign out_res.removed_value = removed_r;
  assign out_res.entry_count   = count_ext[COUNT_OUT_W-1:0];

  // the count register and the cell occupied flags tell the same story
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    full == (count_r == CNT_W'(CAPACITY)))
    else $error("full flag and count disagree");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    empty == (count_r == '0))
    else $error("empty flag and count disagree");

  // a dequeue on a non-empty queue always succeeds
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd.kind == KIND_DEQUEUE) && (count_r != '0)
    |=> out_res.valid && (out_res.status == ST_OK))
    else $error("dequeue on non-empty queue did not succeed");

  // a removed value only comes with a successful transfer
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.removed_value != '0) |-> (out_res.status == ST_OK))
    else $error("removed value with failing status");

endmodule

@@ rtl/blq_cell.sv @@
module blq_cell
  import blq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  fwd_link_t  from_front,
  input  bwd_link_t  from_rear,
  output fwd_link_t  to_rear,
  output bwd_link_t  to_front
);

  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     occ_r, occ_nxt;
  logic                     match;
  logic                     first_here;

  always_comb begin
    match      = occ_r && (value_r == ctrl.target_value);
    first_here = match && !from_front.hit;

    to_rear.value  = value_r;
    to_rear.occ    = occ_r;
    to_rear.hit    = from_front.hit | match;
    to_rear.first  = first_here;
    to_front.value = value_r;
    to_front.occ   = occ_r;

    value_nxt = value_r;
    occ_nxt   = occ_r;
    case (ctrl.op)
      OP_APPEND: begin
        // the first free cell takes the new value
        if (from_front.occ && !occ_r) value_nxt = ctrl.new_value;
        occ_nxt = occ_r | from_front.occ;
      end
      OP_POP: begin
        value_nxt = from_rear.value;
        occ_nxt   = from_rear.occ;
      end
      OP_AFTER: begin
        if (from_front.first) value_nxt = ctrl.new_value;
        else if (from_front.hit) value_nxt = from_front.value;
        occ_nxt = occ_r | from_front.occ;
      end
      OP_BEFORE: begin
        if (first_here) value_nxt = ctrl.new_value;
        else if (from_front.hit) value_nxt = from_front.value;
        occ_nxt = occ_r | from_front.occ;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) occ_r <= 1'b0;
    else        occ_r <= occ_nxt;
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import blq_pkg::*;

  // no transfer on either channel for this many cycles means the block hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 830;
  // final stretch of the random part runs with both sides always willing
  localparam int STEADY_TAIL    = 150;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } queue_result_t;

  // mirror of the queue contents plus the results still owed by the block
  class queue_scoreboard;
    logic signed [DATA_W-1:0] slot [BLQ_CAPACITY];
    int                       occupancy;
    queue_result_t            awaited [$];
    int                       mismatches;
    int                       status_seen [4];
    int                       commands_taken;

    function new();
      occupancy      = 0;
      mismatches     = 0;
      commands_taken = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    // apply one accepted command to the mirror and queue up its result
    function void note_command(logic [1:0] kind, logic signed [DATA_W-1:0] target_value,
                               logic signed [DATA_W-1:0] new_value);
      queue_result_t res;
      int            pos;
      int            hit;
      int            i;
      res.status        = ST_OK;
      res.removed_value = '0;
      pos               = -1;
      case (kind)
        KIND_ENQUEUE: begin
          if (occupancy >= BLQ_CAPACITY) res.status = ST_FULL;
          else pos = occupancy;
        end
        KIND_DEQUEUE: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.removed_value = slot[0];
            for (i = 1; i < occupancy; i++) slot[i-1] = slot[i];
            occupancy--;
          end
        end
        default: begin
          // empty wins over full for the two insert kinds
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else if (occupancy >= BLQ_CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            hit = -1;
            for (i = 0; i < occupancy && hit < 0; i++)
              if (slot[i] == target_value) hit = i;
            if (hit < 0) res.status = ST_NOTFOUND;
            else pos = (kind == KIND_AFTER) ? hit + 1 : hit;
          end
        end
      endcase
      if (pos >= 0) begin
        for (i = occupancy; i > pos; i--) slot[i] = slot[i-1];
        slot[pos] = new_value;
        occupancy++;
      end
      res.entry_count = occupancy[COUNT_OUT_W-1:0];
      awaited.push_back(res);
      commands_taken++;
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d removed %0d count %0d", $time,
                 got.status, got.removed_value, got.entry_count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.removed_value !== want.removed_value) begin
        $display("%0t: removed_value expected %0d actual %0d", $time,
                 want.removed_value, got.removed_value);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  blq_cmd_if cmd_if ();
  blq_res_if res_if ();

  bounded_list_queue u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_if),
    .out_res (res_if)
  );

  queue_scoreboard sb;
  bit              idle_en;
  int              stall_left;
  int              quiet_cycles;
  queue_result_t   seen;

  // small pool of values so that duplicates and repeated targets show up often
  logic signed [DATA_W-1:0] value_pool [6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                                               32'shFFFF_FFFF, 32'sh0000_0001, 32'sh5A5A_A5A5};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one command: optional idle burst first, then hold valid until the transfer
  task automatic drive_cmd(input logic [1:0] kind, input logic signed [DATA_W-1:0] target_value,
                           input logic signed [DATA_W-1:0] new_value);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      cmd_if.valid        <= 1'b0;
      // junk payload while idle, the block must ignore it
      cmd_if.kind         <= 2'($urandom_range(0, 3));
      cmd_if.target_value <= $urandom;
      cmd_if.new_value    <= $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.kind         <= kind;
    cmd_if.target_value <= target_value;
    cmd_if.new_value    <= new_value;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(kind, target_value, new_value);
  endtask

  // result side: check every transfer, stall ready in random bursts
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      seen.status        = res_if.status;
      seen.removed_value = res_if.removed_value;
      seen.entry_count   = res_if.entry_count;
      sb.check_result(seen);
    end
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (idle_en && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 12);
    res_if.ready <= (stall_left == 0);
  end

  // watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[bounded_list_queue] ERROR");
      $finish;
    end
  end

  initial begin
    int                       i;
    int                       n;
    int                       pick;
    int                       phase_left;
    bit                       filling;
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] target_value;
    logic signed [DATA_W-1:0] new_value;

    sb                  = new();
    idle_en             = 1'b1;
    stall_left          = 0;
    quiet_cycles        = 0;
    phase_left          = 0;
    filling             = 1'b1;
    rst_n               = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.kind         = KIND_ENQUEUE;
    cmd_if.target_value = '0;
    cmd_if.new_value    = '0;
    res_if.ready        = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dequeue and both insert kinds on an empty queue
    drive_cmd(KIND_DEQUEUE, '0, '0);
    drive_cmd(KIND_AFTER, '0, 32'sh0000_0009);
    drive_cmd(KIND_BEFORE, '0, 32'sh0000_0009);
    // extremes, with a duplicate of the max value
    drive_cmd(KIND_ENQUEUE, '0, 32'sh8000_0000);
    drive_cmd(KIND_ENQUEUE, '0, 32'sh7FFF_FFFF);
    drive_cmd(KIND_ENQUEUE, '0, 32'sh0000_0000);
    drive_cmd(KIND_ENQUEUE, '0, 32'shFFFF_FFFF);
    drive_cmd(KIND_ENQUEUE, '0, 32'sh7FFF_FFFF);
    // several matches: only the front-most is used
    drive_cmd(KIND_AFTER, 32'sh7FFF_FFFF, 32'sh0000_000B);
    drive_cmd(KIND_BEFORE, 32'shFFFF_FFFF, 32'sh0000_0016);
    // insert ahead of the current front
    drive_cmd(KIND_BEFORE, 32'sh8000_0000, 32'sh0000_0021);
    // target absent
    drive_cmd(KIND_AFTER, 32'sh1234_5678, 32'sh0000_0001);
    drive_cmd(KIND_BEFORE, 32'sh1234_5678, 32'sh0000_0001);
    drive_cmd(KIND_DEQUEUE, '0, '0);
    drive_cmd(KIND_DEQUEUE, '0, '0);
    // fill up, then hit the full case with every adding kind
    for (i = 0; sb.occupancy < BLQ_CAPACITY; i++)
      drive_cmd(KIND_ENQUEUE, '0, i[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA);
    drive_cmd(KIND_ENQUEUE, '0, 32'sh0000_0002);
    drive_cmd(KIND_AFTER, 32'sh7FFF_FFFF, 32'sh0000_0003);
    drive_cmd(KIND_BEFORE, 32'sh0000_0000, 32'sh0000_0004);

    // random: fill and drain phases so the count sweeps between empty and full
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - STEADY_TAIL) idle_en = 1'b0;
      if (phase_left == 0) begin
        filling    = 1'($urandom_range(0, 1));
        phase_left = $urandom_range(8, 48);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (filling) begin
        kind = (pick < 40) ? KIND_ENQUEUE : (pick < 55) ? KIND_DEQUEUE :
               (pick < 78) ? KIND_AFTER : KIND_BEFORE;
      end else begin
        kind = (pick < 15) ? KIND_ENQUEUE : (pick < 55) ? KIND_DEQUEUE :
               (pick < 78) ? KIND_AFTER : KIND_BEFORE;
      end
      // targets mostly taken from what the queue holds right now
      pick = $urandom_range(0, 9);
      if (sb.occupancy != 0 && pick < 7)
        target_value = sb.slot[$urandom_range(0, sb.occupancy - 1)];
      else if (pick < 9)
        target_value = value_pool[$urandom_range(0, 5)];
      else
        target_value = $urandom;
      if ($urandom_range(0, 2) == 0) new_value = value_pool[$urandom_range(0, 5)];
      else new_value = $urandom;
      drive_cmd(kind, target_value, new_value);
    end
    cmd_if.valid <= 1'b0;

    // drain outstanding results, then keep watching for anything spurious
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d commands over empty, partial and full queues", sb.commands_taken);
    $display("results: ok %0d, full %0d, empty %0d, target missing %0d, mismatches %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_NOTFOUND], sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[bounded_list_queue] OK");
    end else begin
      $display("[bounded_list_queue] ERROR");
    end
    $finish;
  end

endmodule
